// ===== rtl/hhn_pkg.sv =====
`timescale 1ns / 1ps

package hhn_pkg;

  // Step counts of the iterative units
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned SQRT_STEPS = 17;
  localparam int unsigned CNT_W      = 6;

  // Quotient of count^2 * 2^32 / sum of squares never exceeds 2^32
  localparam int unsigned Q_W   = 33;
  localparam int unsigned SQV_W = 34;
  localparam int unsigned RT_W  = 17;
  localparam int unsigned SR_W  = 20;

  localparam int unsigned WEIGHT_ONE = 65536;

  typedef struct packed {
    logic [7:0] hue;
    logic       last_pixel;
  } hhn_in_t;

  typedef struct packed {
    logic [4:0]  bin_index;
    logic [16:0] bin_weight;
    logic        empty_image;
    logic        last_bin;
  } hhn_out_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_READ,
    ST_SQUARE,
    ST_DIV_INIT,
    ST_DIV,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_EMIT
  } hhn_state_e;

  typedef struct packed {
    logic read_en;
    logic square;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic emit;
    logic emit_last;
    logic clear;
  } hhn_cmd_t;

endpackage

// ===== rtl/hhn_ctrl.sv =====
`timescale 1ns / 1ps

module hhn_ctrl
  import hhn_pkg::*;
#(
  parameter int unsigned NUM_BINS = 32,
  localparam int unsigned IDX_W   = $clog2(NUM_BINS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             last_i,
  output hhn_cmd_t         cmd_o,
  output logic [IDX_W-1:0] bin_o,
  output logic             busy_o
);

  hhn_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] bin_q, bin_d;
  logic             bin_last;
  logic             div_done;
  logic             sqrt_done;

  assign bin_last  = (bin_q == IDX_W'(NUM_BINS - 1));
  assign div_done  = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign sqrt_done = (cnt_q == CNT_W'(SQRT_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM: begin
        if (accept_i && last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:     state_d = ST_READ;
      ST_READ:      state_d = ST_SQUARE;
      ST_SQUARE:    state_d = ST_DIV_INIT;
      ST_DIV_INIT:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (bin_last) begin
          state_d = ST_ACCUM;
        end else begin
          state_d = ST_READ;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_ACCUM:     busy_o          = 1'b0;
      ST_READ:      cmd_o.read_en   = 1'b1;
      ST_SQUARE:    cmd_o.square    = 1'b1;
      ST_DIV_INIT:  cmd_o.div_init  = 1'b1;
      ST_DIV:       cmd_o.div_step  = 1'b1;
      ST_SQRT_INIT: cmd_o.sqrt_init = 1'b1;
      ST_SQRT:      cmd_o.sqrt_step = 1'b1;
      ST_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = bin_last;
        cmd_o.clear     = bin_last;
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if ((state_q == ST_DIV && !div_done) || (state_q == ST_SQRT && !sqrt_done)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    bin_d = bin_q;
    if (state_q == ST_EMIT) begin
      bin_d = bin_last ? '0 : bin_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      cnt_q   <= '0;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bin_q   <= bin_d;
    end
  end

  assign bin_o = bin_q;

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !(cmd_o.read_en || cmd_o.div_step || cmd_o.sqrt_step || cmd_o.emit))
    else $error("datapath command while accepting pixels");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> (cmd_o.emit && bin_o == IDX_W'(NUM_BINS - 1)))
    else $error("histogram cleared before the final bin");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_i) |=> busy_o)
    else $error("block not busy after the final pixel");
`endif

endmodule

// ===== rtl/hhn_datapath.sv =====
`timescale 1ns / 1ps

module hhn_datapath
  import hhn_pkg::*;
#(
  parameter int unsigned NUM_BINS        = 32,
  parameter int unsigned MAX_PIXELS_LOG2 = 20,
  localparam int unsigned IDX_W          = $clog2(NUM_BINS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_accept_i,
  input  hhn_in_t          pix_i,
  input  hhn_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] bin_i,
  output logic             res_valid_o,
  output hhn_out_t         res_o
);

  localparam int unsigned CW    = MAX_PIXELS_LOG2 + 1;
  localparam int unsigned SW    = 2 * CW + $clog2(NUM_BINS);
  localparam int unsigned SPAN  = 256 / NUM_BINS;
  localparam logic [24:0] RECIP = 25'((2 ** 24 + SPAN - 1) / SPAN);

  // Hue to bin by reciprocal multiply, exact for 8-bit hue
  logic [32:0]      hue_prod;
  logic [8:0]       hue_bin;
  logic             pix_in_range;
  logic [IDX_W-1:0] pix_idx;

  assign hue_prod     = 33'(pix_i.hue) * 33'(RECIP);
  assign hue_bin      = hue_prod[32:24];
  assign pix_in_range = (hue_bin < 9'(NUM_BINS));
  assign pix_idx      = hue_bin[IDX_W-1:0];

  logic [CW-1:0]       cnt_mem [NUM_BINS];
  logic [CW-1:0]       rd_q;
  logic [NUM_BINS-1:0] vld_q;

  logic             s1_v_q;
  logic             s1_in_q;
  logic [IDX_W-1:0] s1_idx_q;

  logic             fwd_v_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [CW-1:0]    fwd_val_q;

  logic [CW-1:0] s1_cnt;
  logic [CW-1:0] s1_inc;
  logic          wr_en;

  logic [SW-1:0] sq_q;

  always_comb begin
    if (fwd_v_q && fwd_idx_q == s1_idx_q) begin
      s1_cnt = fwd_val_q;
    end else if (vld_q[s1_idx_q]) begin
      s1_cnt = rd_q;
    end else begin
      s1_cnt = '0;
    end
  end

  // Count saturates at 2^MAX_PIXELS_LOG2, the only value with the top bit set
  assign s1_inc = s1_cnt + CW'(1);
  assign wr_en  = s1_v_q && s1_in_q && !s1_cnt[CW-1];

  always_ff @(posedge clk_i) begin
    if (pix_accept_i) begin
      rd_q <= cnt_mem[pix_idx];
    end else if (cmd_i.read_en) begin
      rd_q <= cnt_mem[bin_i];
    end
    if (wr_en) begin
      cnt_mem[s1_idx_q] <= s1_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_in_q   <= pix_in_range;
    s1_idx_q  <= pix_idx;
    fwd_idx_q <= s1_idx_q;
    fwd_val_q <= s1_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      vld_q   <= '0;
      sq_q    <= '0;
    end else begin
      s1_v_q <= pix_accept_i;
      if (cmd_i.clear) begin
        fwd_v_q <= 1'b0;
        vld_q   <= '0;
        sq_q    <= '0;
      end else begin
        fwd_v_q <= wr_en;
        if (wr_en) begin
          vld_q[s1_idx_q] <= 1'b1;
          sq_q            <= sq_q + SW'({s1_cnt, 1'b1});
        end
      end
    end
  end

  // Weight = isqrt(floor(c^2 * 2^32 / S))
  logic [CW-1:0]   norm_cnt;
  logic [2*CW-1:0] csq_q;
  logic [SW-1:0]   rem_q;
  logic [SW:0]     rem_sh;
  logic            rem_ge;
  logic [Q_W-1:0]  nb_q;
  logic [Q_W-1:0]  quo_q;
  logic [SQV_W-1:0] sv_q;
  logic [RT_W-1:0]  root_q;
  logic [SR_W-1:0]  srem_q;
  logic [SR_W-1:0]  srem_sh;
  logic [SR_W-1:0]  trial;
  logic             srem_ge;
  logic             empty;

  assign norm_cnt = vld_q[bin_i] ? rd_q : '0;
  assign rem_sh   = {rem_q, nb_q[Q_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, sq_q});
  assign srem_sh  = {srem_q[SR_W-3:0], sv_q[SQV_W-1 -: 2]};
  assign trial    = SR_W'({root_q, 2'b01});
  assign srem_ge  = (srem_sh >= trial);
  assign empty    = (sq_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      csq_q <= (2 * CW)'(norm_cnt) * (2 * CW)'(norm_cnt);
    end
    if (cmd_i.div_init) begin
      rem_q <= SW'(csq_q >> 1);
      nb_q  <= {csq_q[0], {(Q_W - 1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? SW'(rem_sh - {1'b0, sq_q}) : SW'(rem_sh);
      nb_q  <= {nb_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], rem_ge};
    end
    if (cmd_i.sqrt_init) begin
      sv_q   <= SQV_W'(quo_q);
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sv_q   <= {sv_q[SQV_W-3:0], 2'b00};
      root_q <= {root_q[RT_W-2:0], srem_ge};
      srem_q <= srem_ge ? srem_sh - trial : srem_sh;
    end
    if (cmd_i.emit) begin
      res_o.bin_index   <= 5'(bin_i);
      res_o.bin_weight  <= empty ? '0 : root_q;
      res_o.empty_image <= empty;
      res_o.last_bin    <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.emit;
    end
  end

`ifndef SYNTH
  a_res_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(cmd_i.emit))
    else $error("result strobe without an emit");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.bin_weight <= 17'(WEIGHT_ONE)))
    else $error("bin weight above one");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.empty_image) |-> (res_o.bin_weight == '0))
    else $error("non-zero weight for an empty image");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (sq_q == '0 && vld_q == '0))
    else $error("histogram not cleared after the final bin");
`endif

endmodule

// ===== rtl/hue_histogram_l2_normalizer.sv =====
// Hue histogram with L2-normalised bin weights.
// Pixels: one transaction per cycle while busy_o is low; the count update is a
// registered read-modify-write with forwarding of the previous write.
// After the last pixel: a drain state, then per bin a read, square, 33-step divider,
// 17-step square root and emit; a bin's result is emitted before the next bin is read.
// Receiver cannot stall. Reset is asynchronous, active low, and clears the histogram.
`timescale 1ns / 1ps

module hue_histogram_l2_normalizer
  import hhn_pkg::*;
#(
  parameter int unsigned NUM_BINS        = 32,
  parameter int unsigned MAX_PIXELS_LOG2 = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  hhn_in_t  pix_i,
  output logic     res_valid_o,
  output hhn_out_t res_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BINS);

  logic             accept;
  hhn_cmd_t         cmd;
  logic [IDX_W-1:0] bin;

  assign accept = start_i && !busy_o;

  hhn_ctrl #(
    .NUM_BINS (NUM_BINS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .last_i   (pix_i.last_pixel),
    .cmd_o    (cmd),
    .bin_o    (bin),
    .busy_o   (busy_o)
  );

  hhn_datapath #(
    .NUM_BINS        (NUM_BINS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_accept_i (accept),
    .pix_i        (pix_i),
    .cmd_i        (cmd),
    .bin_i        (bin),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule

// ===== tb/hhn_checker.sv =====
`timescale 1ns / 1ps

module hhn_checker
  import hhn_pkg::*;
#(
  parameter int unsigned NUM_BINS        = 32,
  parameter int unsigned MAX_PIXELS_LOG2 = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  hhn_in_t  pix_i,
  input  logic     res_valid_i,
  input  hhn_out_t res_i,
  output int       err_count_o,
  output int       pending_o,
  output int       checked_o
);

  localparam int unsigned     BIN_SPAN    = 256 / NUM_BINS;
  localparam longint unsigned COUNT_LIMIT = 64'd1 << MAX_PIXELS_LOG2;

  longint unsigned hist_q [NUM_BINS];
  longint unsigned sq_sum_q;
  hhn_out_t        weight_q [$];
  hhn_out_t        exp_res;

  // largest w in [0, 1.0] with w*w*sum <= count*count*2^32
  function automatic logic [16:0] l2_weight(longint unsigned cnt, longint unsigned sq);
    logic [127:0]    rhs;
    logic [127:0]    lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    rhs = 128'(cnt * cnt) << 32;
    lo  = 0;
    hi  = 64'(WEIGHT_ONE);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 128'(mid * mid) * 128'(sq);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 17'(lo);
  endfunction

  task automatic count_pixel(hhn_in_t px);
    int unsigned idx;
    logic        empty;
    hhn_out_t    r;
    idx = px.hue / BIN_SPAN;
    if (idx < NUM_BINS && hist_q[idx] < COUNT_LIMIT) begin
      sq_sum_q += 2 * hist_q[idx] + 1;
      hist_q[idx]++;
    end
    if (px.last_pixel) begin
      empty = (sq_sum_q == 0);
      for (int k = 0; k < NUM_BINS; k++) begin
        r.bin_index   = 5'(k);
        r.bin_weight  = empty ? 17'd0 : l2_weight(hist_q[k], sq_sum_q);
        r.empty_image = empty;
        r.last_bin    = (k == NUM_BINS - 1);
        weight_q.push_back(r);
      end
      foreach (hist_q[b]) hist_q[b] = 0;
      sq_sum_q = 0;
    end
  endtask

  task automatic check_field(string name, longint unsigned expv, longint unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist_q[b]) hist_q[b] = 0;
      sq_sum_q = 0;
      weight_q.delete();
      err_count_o = 0;
      checked_o   = 0;
    end else begin
      if (res_valid_i) begin
        if (weight_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual bin %0d weight %0d",
                   $time, res_i.bin_index, res_i.bin_weight);
          err_count_o++;
        end else begin
          exp_res = weight_q.pop_front();
          check_field("bin_index", 64'(exp_res.bin_index), 64'(res_i.bin_index));
          check_field("bin_weight", 64'(exp_res.bin_weight), 64'(res_i.bin_weight));
          check_field("empty_image", 64'(exp_res.empty_image), 64'(res_i.empty_image));
          check_field("last_bin", 64'(exp_res.last_bin), 64'(res_i.last_bin));
          checked_o++;
        end
      end
      if (start_i && !busy_i) count_pixel(pix_i);
    end
    pending_o = weight_q.size();
  end

endmodule

// ===== tb/hue_histogram_l2_normalizer_tb.sv =====
`timescale 1ns / 1ps

module hue_histogram_l2_normalizer_tb;
  import hhn_pkg::*;

  localparam int unsigned NUM_BINS        = 32;
  localparam int unsigned MAX_PIXELS_LOG2 = 20;
  localparam int          CLK_PERIOD      = 20;
  localparam int          RESET_CYCLES    = 6;
  localparam int          RANDOM_ITEMS    = 100;
  localparam int          STALL_LIMIT     = 5000;
  localparam int          TAIL_CYCLES     = 120;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  hhn_in_t  pix_i;
  logic     res_valid_o;
  hhn_out_t res_o;

  int   err_count;
  int   pending;
  int   checked;
  int   stall_cycles = 0;
  int   items_sent   = 0;
  int   images_sent  = 0;
  logic idle_en;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hue_histogram_l2_normalizer #(
    .NUM_BINS        (NUM_BINS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pix_i       (pix_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  hhn_checker #(
    .NUM_BINS        (NUM_BINS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .pix_i       (pix_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // cycles without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] hue, logic last);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      pix_i   <= 9'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    pix_i   <= {hue, last};
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (last) images_sent++;
  endtask

  initial begin
    int          random_items;
    int          len;
    logic        narrow;
    logic [7:0]  base;
    logic [7:0]  hue;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    pix_i        = '0;
    idle_en      = 1'b1;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-pixel images at both hue extremes
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    // bin edges
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd8, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd248, 1'b0);
    send_pixel(8'd255, 1'b1);
    // uneven counts
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd5, 1'b0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd250, 1'b1);
    // alternating bit patterns
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'hF0, 1'b0);
    send_pixel(8'h0F, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      len     = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      narrow  = 1'($urandom_range(0, 1));
      base    = 8'($urandom);
      for (int p = 0; p < len; p++) begin
        hue = narrow ? 8'(base + $urandom_range(0, 23)) : 8'($urandom);
        send_pixel(hue, p == len - 1);
      end
      random_items += len;
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d images over %0d pixel transactions, %0d bin results checked,",
             images_sent, items_sent, checked);
    $display("with single-pixel images, bin edges, uneven counts and random images.");
    if (err_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hhn_pkg.sv
rtl/hhn_ctrl.sv
rtl/hhn_datapath.sv
rtl/hue_histogram_l2_normalizer.sv
tb/hhn_checker.sv
tb/hue_histogram_l2_normalizer_tb.sv
